### rtl/complex_arithmetic_unit_top_defines.svh
// Assertion macros shared by the checker of complex_arithmetic_unit_top.
// Plain text macros only; no dependencies.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CAU_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cau assertion failed");

// next-cycle implication, also checked across reset
`define CAU_ASSERT_NEXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cau assertion failed");

`endif

### rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// No dependencies; used by every module of the block.
`default_nettype none
package cau_pkg;

  localparam int FIELD_W        = 32;
  localparam int OP_W           = 3;
  localparam int MAX_EW         = 32;
  localparam int MAX_FB         = 31;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 4;

  // request codes as seen on req_type
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_MOD = 3'd5
  } op_code_t;

  // work class decided by the front end
  typedef enum logic [2:0] {
    K_ADD, K_SUB, K_MUL, K_DIV, K_EQ, K_MOD, K_DZ, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               eq;
    logic [FIELD_W-1:0] a_re;
    logic [FIELD_W-1:0] a_im;
    logic [FIELD_W-1:0] b_re;
    logic [FIELD_W-1:0] b_im;
  } cau_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROD, ST_MFIN, ST_DSTART, ST_DIV, ST_SQRT, ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

### rtl/cau_front.sv
// Front end: accepts request beats, classifies them, queues them.
// Depends on cau_pkg.
`default_nettype none
module cau_front import cau_pkg::*; #(
  parameter int EW = DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [OP_W-1:0]    req_type,
  input  wire logic [FIELD_W-1:0] a_re,
  input  wire logic [FIELD_W-1:0] a_im,
  input  wire logic [FIELD_W-1:0] b_re,
  input  wire logic [FIELD_W-1:0] b_im,
  output logic                    head_valid,
  output cau_item_t               head,
  input  wire logic               head_take
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cau_item_t      entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  cau_item_t      item;
  logic           accept, take;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign accept     = push && !full;
  assign take       = head_take && head_valid;

  // classify: divide by a zero divisor needs no back-end work
  always_comb begin
    item.a_re = a_re;
    item.a_im = a_im;
    item.b_re = b_re;
    item.b_im = b_im;
    item.eq   = (a_re[EW-1:0] == b_re[EW-1:0]) && (a_im[EW-1:0] == b_im[EW-1:0]);
    case (req_type)
      OP_ADD: item.kind = K_ADD;
      OP_SUB: item.kind = K_SUB;
      OP_MUL: item.kind = K_MUL;
      OP_DIV: begin
        if ((b_re[EW-1:0] == '0) && (b_im[EW-1:0] == '0)) item.kind = K_DZ;
        else item.kind = K_DIV;
      end
      OP_EQ:  item.kind = K_EQ;
      OP_MOD: item.kind = K_MOD;
      default: item.kind = K_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) entries[wr_ptr] <= item;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (take)   rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({accept, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/cau_back.sv
// Back end: executes queued requests with a shared multiplier, a radix-2
// divider and a digit-by-digit square root; holds the result register.
// Depends on cau_pkg.
`default_nettype none
module cau_back import cau_pkg::*; #(
  parameter int EW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire cau_item_t          head,
  output logic                    head_take,
  output logic                    empty,
  input  wire logic               pop,
  output logic [FIELD_W-1:0]      res_re,
  output logic [FIELD_W-1:0]      res_im,
  output logic                    is_equal,
  output logic                    overflow,
  output logic                    divide_by_zero
);

  localparam int PW2 = 2 * EW;
  localparam int AW  = PW2 + 2;
  localparam int DVW = PW2 + FB;
  localparam int QW  = EW + 2;
  localparam int DCW = $clog2(DVW);
  localparam int SCW = $clog2(EW);

  function automatic logic [EW:0] sat_s(input logic signed [AW-1:0] v);
    logic ovf;
    logic [EW-1:0] val;
    ovf = !((&v[AW-1:EW-1]) || !(|v[AW-1:EW-1]));
    if (!ovf) val = v[EW-1:0];
    else if (v[AW-1]) val = {1'b1, {(EW-1){1'b0}}};
    else val = {1'b0, {(EW-1){1'b1}}};
    return {ovf, val};
  endfunction

  function automatic logic [EW:0] sat_q(input logic neg, input logic [QW-1:0] q,
                                        input logic stk);
    logic ovf;
    logic [EW-1:0] val;
    logic [QW-1:0] smax;
    smax = QW'({(EW-1){1'b1}});
    if (!neg) begin
      ovf = stk || (q > smax);
      val = ovf ? {1'b0, {(EW-1){1'b1}}} : q[EW-1:0];
    end else begin
      ovf = stk || (q > smax + 1'b1);
      val = ovf ? {1'b1, {(EW-1){1'b0}}} : (~q[EW-1:0] + 1'b1);
    end
    return {ovf, val};
  endfunction

  back_state_t state, state_next;

  logic signed [EW-1:0]  op_ar, op_ai, op_br, op_bi;
  kind_t                 kind_r;
  logic [2:0]            k, nsteps;
  logic signed [EW-1:0]  mx, my;
  logic signed [PW2-1:0] prod;
  logic signed [AW-1:0]  acc_a, acc_b, pext;
  logic [PW2-1:0]        den;
  logic                  prod_last;
  logic [EW:0]           m_re, m_im;

  logic [DVW-1:0]        dvd;
  logic [PW2-1:0]        rem;
  logic [QW-1:0]         quo, quo_next;
  logic                  sticky, sticky_next, part, neg_r;
  logic [DCW-1:0]        dcnt;
  logic [PW2:0]          r2, r2_sub;
  logic                  dge, div_last;
  logic signed [AW-1:0]  dsel, dabs;
  logic [EW:0]           dsat;

  logic [PW2-1:0]        sbit, sres, sres_next, st;
  logic                  sge, sqrt_last;
  logic [SCW-1:0]        scnt;

  logic [EW-1:0]         res_re_r, res_im_r;
  logic                  ovf_r;

  logic                  out_free, take, emit, simple;
  logic signed [EW-1:0]  har, hai, hbr, hbi;
  logic [EW:0]           s_re, s_im;
  logic [EW-1:0]         e_re, e_im;
  logic                  e_eq, e_ovf, e_dz;

  assign out_free = empty || pop;
  assign har = head.a_re[EW-1:0];
  assign hai = head.a_im[EW-1:0];
  assign hbr = head.b_re[EW-1:0];
  assign hbi = head.b_im[EW-1:0];
  assign simple = !(head.kind == K_MUL || head.kind == K_DIV || head.kind == K_MOD);

  // multiply: floor by arithmetic shift, then saturate
  assign m_re = sat_s(acc_a >>> FB);
  assign m_im = sat_s(acc_b >>> FB);

  // product schedule
  always_comb begin
    case (kind_r)
      K_MUL:   nsteps = 3'd4;
      K_DIV:   nsteps = 3'd6;
      default: nsteps = 3'd2;
    endcase
    prod_last = (k == nsteps);
    mx = op_ar;
    my = op_br;
    if (kind_r == K_MOD) begin
      mx = (k == 3'd0) ? op_ar : op_ai;
      my = mx;
    end else begin
      case (k)
        3'd0: begin mx = op_ar; my = op_br; end
        3'd1: begin mx = op_ai; my = op_bi; end
        3'd2: begin mx = op_ar; my = op_bi; end
        3'd3: begin mx = op_ai; my = op_br; end
        3'd4: begin mx = op_br; my = op_br; end
        3'd5: begin mx = op_bi; my = op_bi; end
        default: begin mx = op_ar; my = op_br; end
      endcase
    end
    pext = AW'(prod);
  end

  // divider step
  always_comb begin
    dsel        = part ? acc_b : acc_a;
    dabs        = dsel[AW-1] ? -dsel : dsel;
    r2          = {rem, dvd[DVW-1]};
    dge         = (r2 >= {1'b0, den});
    r2_sub      = r2 - {1'b0, den};
    quo_next    = {quo[QW-2:0], dge};
    sticky_next = sticky || quo[QW-1];
    div_last    = (dcnt == DCW'(DVW - 1));
    dsat        = sat_q(neg_r, quo_next, sticky_next);
  end

  // square root step
  always_comb begin
    st        = sres + sbit;
    sge       = (den >= st);
    sres_next = sge ? ((sres >> 1) + sbit) : (sres >> 1);
    sqrt_last = (scnt == SCW'(EW - 1));
  end

  // simple ops straight from the queue head
  always_comb begin
    s_re = '0;
    s_im = '0;
    case (head.kind)
      K_ADD: begin
        s_re = sat_s(AW'(har) + AW'(hbr));
        s_im = sat_s(AW'(hai) + AW'(hbi));
      end
      K_SUB: begin
        s_re = sat_s(AW'(har) - AW'(hbr));
        s_im = sat_s(AW'(hai) - AW'(hbi));
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (head_valid && !simple) state_next = ST_PROD;
      ST_PROD: begin
        if (prod_last) begin
          case (kind_r)
            K_MUL:   state_next = ST_MFIN;
            K_DIV:   state_next = ST_DSTART;
            default: state_next = ST_SQRT;
          endcase
        end
      end
      ST_MFIN:   state_next = ST_DONE;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (div_last) state_next = part ? ST_DONE : ST_DSTART;
      ST_SQRT:   if (sqrt_last) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    take  = 1'b0;
    emit  = 1'b0;
    e_re  = res_re_r;
    e_im  = res_im_r;
    e_eq  = 1'b0;
    e_ovf = ovf_r;
    e_dz  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          if (simple) begin
            take  = out_free;
            emit  = out_free;
            e_re  = s_re[EW-1:0];
            e_im  = s_im[EW-1:0];
            e_ovf = s_re[EW] || s_im[EW];
            e_eq  = (head.kind == K_EQ) && head.eq;
            e_dz  = (head.kind == K_DZ);
          end else begin
            take = 1'b1;
          end
        end
      end
      ST_DONE: emit = out_free;
      default: begin
        take = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign head_take = take;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take && !simple) begin
      op_ar    <= har;
      op_ai    <= hai;
      op_br    <= hbr;
      op_bi    <= hbi;
      kind_r   <= head.kind;
      k        <= '0;
      acc_a    <= '0;
      acc_b    <= '0;
      den      <= '0;
      ovf_r    <= 1'b0;
      res_im_r <= '0;
      part     <= 1'b0;
    end
    if (state == ST_PROD) begin
      prod <= mx * my;
      k    <= k + 1'b1;
      if (k != 3'd0) begin
        case (kind_r)
          K_MUL: begin
            case (k)
              3'd1: acc_a <= acc_a + pext;
              3'd2: acc_a <= acc_a - pext;
              default: acc_b <= acc_b + pext;
            endcase
          end
          K_DIV: begin
            case (k)
              3'd1, 3'd2: acc_a <= acc_a + pext;
              3'd3: acc_b <= acc_b - pext;
              3'd4: acc_b <= acc_b + pext;
              default: den <= den + prod;
            endcase
          end
          default: den <= den + prod;
        endcase
      end
      if (prod_last) begin
        sbit <= PW2'(1) << (PW2 - 2);
        sres <= '0;
        scnt <= '0;
      end
    end
    if (state == ST_MFIN) begin
      res_re_r <= m_re[EW-1:0];
      res_im_r <= m_im[EW-1:0];
      ovf_r    <= m_re[EW] || m_im[EW];
    end
    if (state == ST_DSTART) begin
      dvd    <= DVW'(dabs[PW2-1:0]) << FB;
      neg_r  <= dsel[AW-1];
      rem    <= '0;
      quo    <= '0;
      sticky <= 1'b0;
      dcnt   <= '0;
    end
    if (state == ST_DIV) begin
      dvd    <= dvd << 1;
      rem    <= dge ? r2_sub[PW2-1:0] : r2[PW2-1:0];
      quo    <= quo_next;
      sticky <= sticky_next;
      dcnt   <= dcnt + 1'b1;
      if (div_last) begin
        part <= 1'b1;
        if (part) res_im_r <= dsat[EW-1:0];
        else res_re_r <= dsat[EW-1:0];
        if (dsat[EW]) ovf_r <= 1'b1;
      end
    end
    if (state == ST_SQRT) begin
      if (sge) den <= den - st;
      sres <= sres_next;
      sbit <= sbit >> 2;
      scnt <= scnt + 1'b1;
      if (sqrt_last) begin
        ovf_r    <= |sres_next[PW2-1:EW-1];
        res_re_r <= (|sres_next[PW2-1:EW-1]) ? {1'b0, {(EW-1){1'b1}}} : sres_next[EW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      res_re         <= FIELD_W'(signed'(e_re));
      res_im         <= FIELD_W'(signed'(e_im));
      is_equal       <= e_eq;
      overflow       <= e_ovf;
      divide_by_zero <= e_dz;
    end
    if (rst) empty <= 1'b1;
    else if (emit) empty <= 1'b0;
    else if (pop) empty <= 1'b1;
  end

endmodule
`default_nettype wire

### rtl/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: front end, queue, back end.
// Depends on cau_pkg, cau_front and cau_back.
//
// Complex ALU on signed fixed-point parts (Q16.16 by default). Requests enter
// through a queue-like port (push/full) and results leave through another
// (empty/pop); one result beat per request, in request order. The front end
// classifies each beat and parks it in a four-entry queue, so requests keep
// streaming in while the back end works. Add, subtract, equal test, invalid
// codes and divide by a zero divisor finish at one beat per cycle while the
// output register is empty or being popped. The rest run on one shared
// 2*DATA_WIDTH-bit multiplier, one product a cycle. Modulus ends in a digit
// square root, one result bit a cycle; divide ends in a restoring divider,
// one quotient bit a cycle, real then imaginary part. Every request is
// written into the queue before it reaches the head. A result waiting in the
// output register does not block new requests until the four-entry queue
// fills. DATA_WIDTH above 32 acts as 32, FRAC_BITS above 31 acts as 31.
`default_nettype none
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [OP_W-1:0]           req_type,
  input  wire logic signed [FIELD_W-1:0] a_re,
  input  wire logic signed [FIELD_W-1:0] a_im,
  input  wire logic signed [FIELD_W-1:0] b_re,
  input  wire logic signed [FIELD_W-1:0] b_im,
  output logic                           empty,
  input  wire logic                      pop,
  output logic signed [FIELD_W-1:0]      res_re,
  output logic signed [FIELD_W-1:0]      res_im,
  output logic                           is_equal,
  output logic                           overflow,
  output logic                           divide_by_zero
);

  // effective widths
  localparam int EW = (DATA_WIDTH > MAX_EW) ? MAX_EW : DATA_WIDTH;
  localparam int FB = (FRAC_BITS > MAX_FB) ? MAX_FB : FRAC_BITS;

  logic      head_valid, head_take;
  cau_item_t head;

  cau_front #(.EW(EW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .a_re       (a_re),
    .a_im       (a_im),
    .b_re       (b_re),
    .b_im       (b_im),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take)
  );

  cau_back #(.EW(EW), .FB(FB)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .head_take      (head_take),
    .empty          (empty),
    .pop            (pop),
    .res_re         (res_re),
    .res_im         (res_im),
    .is_equal       (is_equal),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

endmodule
`default_nettype wire

### rtl/cau_checker.sv
// Port-level checks for complex_arithmetic_unit_top, attached by bind.
// Depends on cau_pkg and complex_arithmetic_unit_top_defines.svh.
`default_nettype none
`include "complex_arithmetic_unit_top_defines.svh"
module cau_checker import cau_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic [FIELD_W-1:0] res_re,
  input wire logic [FIELD_W-1:0] res_im,
  input wire logic               is_equal,
  input wire logic               overflow,
  input wire logic               divide_by_zero
);

  `CAU_ASSERT_NEXT(a_reset_empty, clk, rst, empty)
  `CAU_ASSERT_IMP(a_eq_clean, clk, rst, !empty && is_equal,
    res_re == '0 && res_im == '0 && !overflow && !divide_by_zero)
  `CAU_ASSERT_IMP(a_dz_clean, clk, rst, !empty && divide_by_zero,
    res_re == '0 && res_im == '0 && !overflow && !is_equal)
  `CAU_ASSERT_NEXT(a_hold_result, clk, !rst && !empty && !pop, rst || !empty)

endmodule
bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);
`default_nettype wire
